// ===== hdl/hlab_pkg.sv =====
// Package for the Hunter Lab converter: widths, register indices, reset values
// and the sideband structures that travel with each pixel through the pipeline.
// Depends on nothing.
`default_nettype none

package hlab_pkg;

    // Internal precision of the ratios and of the square root, in fraction bits.
    localparam int PREC      = 20;
    localparam int IN_W      = 16;
    localparam int RATIO_W   = IN_W + PREC;        // X/Xn etc. in Q.PREC
    localparam int DIVQ_W    = IN_W + 2 * PREC;    // Y/Yn in Q.2*PREC
    localparam int ROOT_W    = DIVQ_W / 2;         // sqrt(Y/Yn) in Q.PREC
    localparam int COEF_W    = 16;
    localparam int SCALE_W   = 7;
    localparam int LPROD_W   = SCALE_W + ROOT_W;
    localparam int MAG_W     = RATIO_W;
    localparam int PROD_W    = COEF_W + MAG_W;
    localparam int NUM_W     = PROD_W + 1;
    localparam int AB_W      = 20;
    localparam int CQ_W      = AB_W + 1;           // chroma quotient bits kept
    localparam int HI_W      = NUM_W - CQ_W;
    localparam int L_W       = 16;

    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_WHITE_X   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WHITE_Y   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WHITE_Z   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KA        = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_KB        = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_L_SCALE   = 3'd5;

    // D65 defaults.
    localparam logic [15:0]        RST_WHITE_X = 16'd24325;
    localparam logic [15:0]        RST_WHITE_Y = 16'd25600;
    localparam logic [15:0]        RST_WHITE_Z = 16'd27858;
    localparam logic [15:0]        RST_KA      = 16'd44109;
    localparam logic [15:0]        RST_KB      = 16'd17203;
    localparam logic [SCALE_W-1:0] RST_L_SCALE = 7'd100;

    localparam logic [AB_W-1:0] AB_MAX_VAL = 20'h7FFFF;
    localparam logic [AB_W-1:0] AB_MIN_VAL = 20'h80000;
    localparam logic [CQ_W-1:0] AB_NEG_LIM = 21'd524288;

    typedef struct packed {
        logic [RATIO_W-1:0] rx;
        logic [RATIO_W-1:0] ry;
        logic [RATIO_W-1:0] rz;
        logic               zero;
    } sq_side_t;

    typedef struct packed {
        logic [L_W-1:0] l;
        logic           lclip;
        logic           neg_a;
        logic           ovf_a;
        logic           neg_b;
        logic           ovf_b;
        logic           zero;
    } cd_side_t;

endpackage

`default_nettype wire

// ===== hdl/hlab_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per register stage, several lanes
// sharing one valid bit and one sideband. Stand-alone, no package needed.
`default_nettype none

module hlab_div_pipe #(
    parameter int LANES = 1,
    parameter int QW    = 8,
    parameter int DW    = 8,
    parameter int SW    = 1
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          ce,
    input  wire logic                          in_valid,
    input  wire logic [LANES-1:0][QW-1:0]      num_i,
    input  wire logic [LANES-1:0][DW-1:0]      den_i,
    input  wire logic [LANES-1:0][DW-1:0]      rem_i,
    input  wire logic [SW-1:0]                 side_i,
    output logic                               out_valid,
    output logic [LANES-1:0][QW-1:0]           quot_o,
    output logic [SW-1:0]                      side_o
);

    logic                     vld_reg  [0:QW-1];
    logic [LANES-1:0][QW-1:0] nq_reg   [0:QW-1];
    logic [LANES-1:0][DW-1:0] rem_reg  [0:QW-1];
    logic [LANES-1:0][DW-1:0] den_reg  [0:QW-1];
    logic [SW-1:0]            side_reg [0:QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic                     vld_in;
        logic [LANES-1:0][QW-1:0] nq_in;
        logic [LANES-1:0][DW-1:0] rem_in;
        logic [LANES-1:0][DW-1:0] den_in;
        logic [SW-1:0]            side_in;
        logic [LANES-1:0][QW-1:0] nq_next;
        logic [LANES-1:0][DW-1:0] rem_next;
        logic [LANES-1:0][DW:0]   trial;
        logic [LANES-1:0][DW:0]   diff;
        logic [LANES-1:0]         ge;

        if (k == 0) begin : g_first
            assign vld_in  = in_valid;
            assign nq_in   = num_i;
            assign rem_in  = rem_i;
            assign den_in  = den_i;
            assign side_in = side_i;
        end else begin : g_rest
            assign vld_in  = vld_reg[k-1];
            assign nq_in   = nq_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                trial[l]    = {rem_in[l], nq_in[l][QW-1]};
                diff[l]     = trial[l] - {1'b0, den_in[l]};
                ge[l]       = trial[l] >= {1'b0, den_in[l]};
                rem_next[l] = ge[l] ? diff[l][DW-1:0] : trial[l][DW-1:0];
                nq_next[l]  = {nq_in[l][QW-2:0], ge[l]};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (ce) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                nq_reg[k]   <= nq_next;
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quot_o    = nq_reg[QW-1];
    assign side_o    = side_reg[QW-1];

endmodule

`default_nettype wire

// ===== hdl/hlab_sqrt_pipe.sv =====
// Pipelined integer square root, one root bit per register stage, with a sideband
// that travels alongside. Stand-alone, no package needed.
`default_nettype none

module hlab_sqrt_pipe #(
    parameter int RW = 8,
    parameter int SW = 1
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            ce,
    input  wire logic            in_valid,
    input  wire logic [2*RW-1:0] val_i,
    input  wire logic [SW-1:0]   side_i,
    output logic                 out_valid,
    output logic [RW-1:0]        root_o,
    output logic [SW-1:0]        side_o
);

    logic            vld_reg  [0:RW-1];
    logic [2*RW-1:0] val_reg  [0:RW-1];
    logic [RW+1:0]   rem_reg  [0:RW-1];
    logic [RW-1:0]   root_reg [0:RW-1];
    logic [SW-1:0]   side_reg [0:RW-1];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic            vld_in;
        logic [2*RW-1:0] val_in;
        logic [RW+1:0]   rem_in;
        logic [RW-1:0]   root_in;
        logic [SW-1:0]   side_in;
        logic [RW+3:0]   acc;
        logic [RW+3:0]   trial;
        logic [RW+3:0]   diff;
        logic            ge;

        if (k == 0) begin : g_first
            assign vld_in  = in_valid;
            assign val_in  = val_i;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = side_i;
        end else begin : g_rest
            assign vld_in  = vld_reg[k-1];
            assign val_in  = val_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign acc   = {rem_in, val_in[2*RW-1:2*RW-2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign diff  = acc - trial;
        assign ge    = acc >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (ce) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                val_reg[k]  <= {val_in[2*RW-3:0], 2'b00};
                rem_reg[k]  <= ge ? diff[RW+1:0] : acc[RW+1:0];
                root_reg[k] <= {root_in[RW-2:0], ge};
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign root_o    = root_reg[RW-1];
    assign side_o    = side_reg[RW-1];

endmodule

`default_nettype wire

// ===== hdl/xyz_to_hunter_lab.sv =====
// Top level of the XYZ to Hunter Lab converter: configuration registers, the
// arithmetic stages between the divider and root pipelines, and the output buffer.
// Depends on hlab_pkg, hlab_div_pipe and hlab_sqrt_pipe.
//
// Usage. One XYZ colour (unsigned Q8.8 per component) arrives per beat on the
// s_ channel and one Hunter Lab result leaves per beat on the m_ channel, in
// order. s_tdata holds x_value, y_value and z_value from the lowest bit up;
// m_tdata holds lightness, red_green and yellow_blue, and m_tuser is the clip flag.
// The block takes a new beat in every cycle while s_tready is high. Each beat
// passes the input register, the 56-stage divider that forms Y/Yn to 40 fraction
// bits, the 28-stage square root, three register stages between the pipelines,
// the 21-stage chroma divider, the final register and the output register, six
// plain register stages in all.
// Reset (aresetn low at a clock edge) empties the pipeline and loads the D65
// white point, Ka, Kb and a lightness scale of 100. Configuration writes must be
// made only while no beat is in flight.
// When the receiver stalls, a finished result waits in the output register and
// one more is caught in a skid register; only once that is full does s_tready
// drop and the whole pipeline hold, losing and repeating nothing.
`default_nettype none

module xyz_to_hunter_lab import hlab_pkg::*; #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Configuration write port.
    input  wire logic                 cfg_wr_en,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_wr_data,
    // Input stream.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [47:0]          s_tdata,   // x_value, y_value, z_value
    // Result stream.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [55:0]               m_tdata,   // lightness, red_green, yellow_blue
    output logic [0:0]                m_tuser    // clipped
);

    localparam int LSHIFT = PREC - FRAC_BITS;
    localparam int LSUM_W = LPROD_W + 1;
    localparam logic [LSUM_W-1:0] L_RND = LSUM_W'(1) << (LSHIFT - 1);

    // Configuration registers.
    logic [15:0]        white_x_reg, white_y_reg, white_z_reg, ka_reg, kb_reg;
    logic [SCALE_W-1:0] scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            white_x_reg <= RST_WHITE_X;
            white_y_reg <= RST_WHITE_Y;
            white_z_reg <= RST_WHITE_Z;
            ka_reg      <= RST_KA;
            kb_reg      <= RST_KB;
            scale_reg   <= RST_L_SCALE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_WHITE_X: white_x_reg <= cfg_wr_data;
                REG_WHITE_Y: white_y_reg <= cfg_wr_data;
                REG_WHITE_Z: white_z_reg <= cfg_wr_data;
                REG_KA:      ka_reg      <= cfg_wr_data;
                REG_KB:      kb_reg      <= cfg_wr_data;
                REG_L_SCALE: scale_reg   <= cfg_wr_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // A zero white component is treated as one so the ratio dividers never see zero.
    logic [15:0] xn, yn, zn;
    assign xn = (white_x_reg == '0) ? 16'd1 : white_x_reg;
    assign yn = (white_y_reg == '0) ? 16'd1 : white_y_reg;
    assign zn = (white_z_reg == '0) ? 16'd1 : white_z_reg;

    // The whole pipeline advances while the skid register is empty.
    logic skid_valid_reg;
    logic ce;
    assign ce       = !skid_valid_reg;
    assign s_tready = ce;

    // Input register.
    logic              in_valid_reg;
    logic [IN_W-1:0]   x_reg, y_reg, z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (ce) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            x_reg <= s_tdata[15:0];
            y_reg <= s_tdata[31:16];
            z_reg <= s_tdata[47:32];
        end
    end

    // Ratio dividers: X/Xn and Z/Zn to PREC fraction bits, Y/Yn to twice that.
    logic [2:0][DIVQ_W-1:0] div_num, div_quot;
    logic [2:0][15:0]       div_den;
    logic                   div_valid;
    logic [0:0]             div_side;

    assign div_num[0] = {{PREC{1'b0}}, x_reg, {PREC{1'b0}}};
    assign div_num[1] = {y_reg, {(2*PREC){1'b0}}};
    assign div_num[2] = {{PREC{1'b0}}, z_reg, {PREC{1'b0}}};
    assign div_den[0] = xn;
    assign div_den[1] = yn;
    assign div_den[2] = zn;

    hlab_div_pipe #(
        .LANES (3),
        .QW    (DIVQ_W),
        .DW    (16),
        .SW    (1)
    ) u_ratio_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (in_valid_reg),
        .num_i     (div_num),
        .den_i     (div_den),
        .rem_i     ('0),
        .side_i    (y_reg == '0),
        .out_valid (div_valid),
        .quot_o    (div_quot),
        .side_o    (div_side)
    );

    // Square root of Y/Yn; the three ratios ride along.
    sq_side_t            sq_in, sq_out;
    logic                sq_valid;
    logic [ROOT_W-1:0]   sq_root;

    assign sq_in.rx   = div_quot[0][RATIO_W-1:0];
    assign sq_in.ry   = div_quot[1][DIVQ_W-1:PREC];
    assign sq_in.rz   = div_quot[2][RATIO_W-1:0];
    assign sq_in.zero = div_side[0];

    hlab_sqrt_pipe #(
        .RW (ROOT_W),
        .SW ($bits(sq_side_t))
    ) u_root (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (div_valid),
        .val_i     (div_quot[1]),
        .side_i    (sq_in),
        .out_valid (sq_valid),
        .root_o    (sq_root),
        .side_o    (sq_out)
    );

    // Differences, signs and magnitudes; the lightness product.
    logic [RATIO_W:0]  diff_a, diff_b;
    assign diff_a = {1'b0, sq_out.rx} - {1'b0, sq_out.ry};
    assign diff_b = {1'b0, sq_out.ry} - {1'b0, sq_out.rz};

    logic                d_valid_reg;
    logic [MAG_W-1:0]    d_mag_a_reg, d_mag_b_reg;
    logic                d_neg_a_reg, d_neg_b_reg, d_zero_reg;
    logic [ROOT_W-1:0]   d_root_reg;
    logic [LPROD_W-1:0]  d_lprod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (ce) begin
            d_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d_neg_a_reg <= diff_a[RATIO_W];
            d_neg_b_reg <= diff_b[RATIO_W];
            d_mag_a_reg <= diff_a[RATIO_W] ? MAG_W'(-diff_a) : diff_a[MAG_W-1:0];
            d_mag_b_reg <= diff_b[RATIO_W] ? MAG_W'(-diff_b) : diff_b[MAG_W-1:0];
            d_zero_reg  <= sq_out.zero || (sq_root == '0);
            d_root_reg  <= sq_root;
            d_lprod_reg <= LPROD_W'(scale_reg) * LPROD_W'(sq_root);
        end
    end

    // Chroma products and the rounded, saturated lightness.
    logic [LSUM_W-1:0] lsum, lsh;
    logic              lclip;
    assign lsum  = {1'b0, d_lprod_reg} + L_RND;
    assign lsh   = lsum >> LSHIFT;
    assign lclip = |lsh[LSUM_W-1:L_W];

    logic               p_valid_reg;
    logic [PROD_W-1:0]  p_prod_a_reg, p_prod_b_reg;
    logic [ROOT_W-1:0]  p_root_reg;
    logic               p_neg_a_reg, p_neg_b_reg, p_zero_reg, p_lclip_reg;
    logic [L_W-1:0]     p_l_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (ce) begin
            p_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            p_prod_a_reg <= PROD_W'(ka_reg) * PROD_W'(d_mag_a_reg);
            p_prod_b_reg <= PROD_W'(kb_reg) * PROD_W'(d_mag_b_reg);
            p_root_reg   <= d_root_reg;
            p_neg_a_reg  <= d_neg_a_reg;
            p_neg_b_reg  <= d_neg_b_reg;
            p_zero_reg   <= d_zero_reg;
            p_lclip_reg  <= lclip;
            p_l_reg      <= lclip ? {L_W{1'b1}} : lsh[L_W-1:0];
        end
    end

    // Add half the divisor for rounding, then split off the high part. If the
    // high part already reaches the divisor the quotient is far out of range.
    logic [NUM_W-1:0] num_a, num_b;
    logic             ovf_a, ovf_b;
    assign num_a = {1'b0, p_prod_a_reg} + NUM_W'(p_root_reg >> 1);
    assign num_b = {1'b0, p_prod_b_reg} + NUM_W'(p_root_reg >> 1);
    assign ovf_a = num_a[NUM_W-1:CQ_W] >= HI_W'(p_root_reg);
    assign ovf_b = num_b[NUM_W-1:CQ_W] >= HI_W'(p_root_reg);

    logic                    n_valid_reg;
    logic [1:0][CQ_W-1:0]    n_low_reg;
    logic [1:0][ROOT_W-1:0]  n_rem_reg;
    logic [ROOT_W-1:0]       n_root_reg;
    cd_side_t                n_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_valid_reg <= 1'b0;
        end else if (ce) begin
            n_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            n_low_reg[0]     <= num_a[CQ_W-1:0];
            n_low_reg[1]     <= num_b[CQ_W-1:0];
            n_rem_reg[0]     <= ovf_a ? '0 : num_a[CQ_W+ROOT_W-1:CQ_W];
            n_rem_reg[1]     <= ovf_b ? '0 : num_b[CQ_W+ROOT_W-1:CQ_W];
            n_root_reg       <= p_root_reg;
            n_side_reg.l     <= p_l_reg;
            n_side_reg.lclip <= p_lclip_reg;
            n_side_reg.neg_a <= p_neg_a_reg;
            n_side_reg.ovf_a <= ovf_a;
            n_side_reg.neg_b <= p_neg_b_reg;
            n_side_reg.ovf_b <= ovf_b;
            n_side_reg.zero  <= p_zero_reg;
        end
    end

    // Chroma divider: the low quotient bits of Ka*|da|/s and Kb*|db|/s.
    logic                    cd_valid;
    logic [1:0][CQ_W-1:0]    cd_quot;
    cd_side_t                cd_side;

    hlab_div_pipe #(
        .LANES (2),
        .QW    (CQ_W),
        .DW    (ROOT_W),
        .SW    ($bits(cd_side_t))
    ) u_chroma_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (n_valid_reg),
        .num_i     (n_low_reg),
        .den_i     ({n_root_reg, n_root_reg}),
        .rem_i     (n_rem_reg),
        .side_i    (n_side_reg),
        .out_valid (cd_valid),
        .quot_o    (cd_quot),
        .side_o    (cd_side)
    );

    // Sign and saturation of a chroma quotient: {clip, value}.
    function automatic logic [AB_W:0] sat_ab(input logic [CQ_W-1:0] q,
                                             input logic neg, input logic ovf);
        logic [CQ_W-1:0] nq;
        logic            clip;
        logic [AB_W-1:0] val;
        nq = -q;
        if (neg) begin
            clip = ovf || (q > AB_NEG_LIM);
            val  = clip ? AB_MIN_VAL : nq[AB_W-1:0];
        end else begin
            clip = ovf || (q > CQ_W'(AB_MAX_VAL));
            val  = clip ? AB_MAX_VAL : q[AB_W-1:0];
        end
        return {clip, val};
    endfunction

    logic [AB_W:0] sat_a, sat_b;
    assign sat_a = sat_ab(cd_quot[0], cd_side.neg_a, cd_side.ovf_a);
    assign sat_b = sat_ab(cd_quot[1], cd_side.neg_b, cd_side.ovf_b);

    // Final stage: a zero Y gives an all-zero result.
    logic        f_valid_reg;
    logic [55:0] f_data_reg;
    logic        f_clip_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (ce) begin
            f_valid_reg <= cd_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            if (cd_side.zero) begin
                f_data_reg <= '0;
                f_clip_reg <= 1'b0;
            end else begin
                f_data_reg <= {sat_b[AB_W-1:0], sat_a[AB_W-1:0], cd_side.l};
                f_clip_reg <= cd_side.lclip || sat_a[AB_W] || sat_b[AB_W];
            end
        end
    end

    // Output register and skid register.
    logic        m_valid_reg;
    logic [55:0] m_data_reg, skid_data_reg;
    logic        m_clip_reg, skid_clip_reg;
    logic        take;
    assign take = m_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (ce) begin
            if (f_valid_reg) begin
                if (!m_valid_reg || take) begin
                    m_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (take) begin
                m_valid_reg <= 1'b0;
            end
        end else if (take) begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            if (f_valid_reg) begin
                if (!m_valid_reg || take) begin
                    m_data_reg <= f_data_reg;
                    m_clip_reg <= f_clip_reg;
                end else begin
                    skid_data_reg <= f_data_reg;
                    skid_clip_reg <= f_clip_reg;
                end
            end
        end else if (take) begin
            m_data_reg <= skid_data_reg;
            m_clip_reg <= skid_clip_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_clip_reg;

    // The skid register only ever holds a beat behind a waiting output beat.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid register full while output register empty");

    // The skid register fills or stays full only while the output is stalled.
    a_skid_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> $past(m_valid_reg && !m_tready))
        else $error("skid register full without an output stall");

    // A waiting result disappears only when it has been taken.
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_valid_reg) |-> $past(m_tready))
        else $error("output beat dropped without handshake");

endmodule

`default_nettype wire
